[rtl/hsv2rgb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants and types for the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HueTurn   = 360;
  localparam int SectorDeg = 60;
  localparam int ChanMax   = 255;
  // Offset that lifts any 11-bit signed hue into positive range.
  localparam int HueBias   = 3 * HueTurn;

  // Middle channel: floor(n / 15300) = (n * MidRecip) >> MidShift for n < 2^22.
  localparam int            MidShift = 36;
  localparam logic [22:0]   MidRecip = 23'd4491470;

  typedef logic [8:0] hue_t;   // folded hue, 0..359
  typedef logic [5:0] frac_t;  // ramp position in a sector, 0..60

  // Sector naming: largest channel, then middle channel.
  typedef enum logic [2:0] {
    SEC_RED_GRN = 3'd0,
    SEC_GRN_RED = 3'd1,
    SEC_GRN_BLU = 3'd2,
    SEC_BLU_GRN = 3'd3,
    SEC_BLU_RED = 3'd4,
    SEC_RED_BLU = 3'd5
  } sector_e;

endpackage

[rtl/hsv2rgb_hue_fold.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_hue_fold
// Folds a signed 11-bit hue in degrees into 0..359 (non-negative modulo).
// ----------------------------------------------------------------------------
module hsv2rgb_hue_fold (
  input  logic signed [10:0]   hue_degrees_i,
  output hsv2rgb_pkg::hue_t    hue_o
);
  import hsv2rgb_pkg::*;

  logic [11:0] biased;

  // Biased value lies in 56..2103, so at most five turns come off.
  assign biased = 12'(13'(hue_degrees_i) + 13'(HueBias));

  always_comb begin
    if (biased >= 12'(5 * HueTurn)) begin
      hue_o = 9'(biased - 12'(5 * HueTurn));
    end else if (biased >= 12'(4 * HueTurn)) begin
      hue_o = 9'(biased - 12'(4 * HueTurn));
    end else if (biased >= 12'(3 * HueTurn)) begin
      hue_o = 9'(biased - 12'(3 * HueTurn));
    end else if (biased >= 12'(2 * HueTurn)) begin
      hue_o = 9'(biased - 12'(2 * HueTurn));
    end else if (biased >= 12'(HueTurn)) begin
      hue_o = 9'(biased - 12'(HueTurn));
    end else begin
      hue_o = 9'(biased);
    end
  end

endmodule

[rtl/hsv_to_rgb_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Pipelined HSV to 8-bit RGB pixel converter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one pixel per beat: a
//   signed hue in degrees plus 8-bit saturation and brightness. The output
//   channel (out_valid_o / out_stall_i) carries one RGB beat per input beat,
//   in order.
//   Throughput is one pixel per clock while out_stall_i is low; the pipe
//   is hue fold, sector/products, middle-channel numerator, reciprocal
//   multiply, channel select, each stage registered.
//   Each stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles collapse during a stall and new pixels
//   are taken until every stage holds a beat. A stalled output beat holds.
//   Reset empties all stages; no output beat is pending after reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [10:0] hue_degrees_i,
  input  logic [7:0]         saturation_i,
  input  logic [7:0]         brightness_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o
);
  import hsv2rgb_pkg::*;

  // Stage load enables, back to front.
  logic ld1, ld2, ld3, ld4, ld5;

  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;

  // Stage 1: folded hue
  hue_t        hue_d, s1_hue_q;
  logic [7:0]  s1_sat_q, s1_val_q;

  // Stage 2: sector, ramp, products
  sector_e     sec_d, s2_sec_q;
  frac_t       frac_d, s2_frac_q;
  logic [7:0]  s2_val_q;
  logic [15:0] plo_d, pvs_d, s2_plo_q, s2_pvs_q;

  // Stage 3: middle numerator
  logic [21:0] num_d, s3_num_q;
  logic [15:0] s3_plo_q;
  logic [7:0]  s3_val_q;
  sector_e     s3_sec_q;

  // Stage 4: reciprocal product, smallest channel
  logic [44:0] prod_d, s4_prod_q;
  logic [16:0] lo_sum;
  logic [7:0]  lo_d, s4_lo_q, s4_val_q;
  sector_e     s4_sec_q;

  // Stage 5: output
  logic [7:0]  mid;
  logic [7:0]  red_d, green_d, blue_d, red_q, green_q, blue_q;

  assign ld5 = !out_valid_q || !out_stall_i;
  assign ld4 = !s4_valid_q || ld5;
  assign ld3 = !s3_valid_q || ld4;
  assign ld2 = !s2_valid_q || ld3;
  assign ld1 = !s1_valid_q || ld2;

  assign in_stall_o = !ld1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld1) s1_valid_q  <= in_valid_i;
      if (ld2) s2_valid_q  <= s1_valid_q;
      if (ld3) s3_valid_q  <= s2_valid_q;
      if (ld4) s4_valid_q  <= s3_valid_q;
      if (ld5) out_valid_q <= s4_valid_q;
    end
  end

  // ---------------- stage 1 ----------------
  hsv2rgb_hue_fold u_fold (
    .hue_degrees_i (hue_degrees_i),
    .hue_o         (hue_d)
  );

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      s1_hue_q <= hue_d;
      s1_sat_q <= saturation_i;
      s1_val_q <= brightness_i;
    end
  end

  // ---------------- stage 2 ----------------
  logic [8:0] sec_base;
  logic [5:0] offs;
  logic [7:0] inv_sat;

  always_comb begin
    if (s1_hue_q >= 9'(5 * SectorDeg)) begin
      sec_d    = SEC_RED_BLU;
      sec_base = 9'(5 * SectorDeg);
    end else if (s1_hue_q >= 9'(4 * SectorDeg)) begin
      sec_d    = SEC_BLU_RED;
      sec_base = 9'(4 * SectorDeg);
    end else if (s1_hue_q >= 9'(3 * SectorDeg)) begin
      sec_d    = SEC_BLU_GRN;
      sec_base = 9'(3 * SectorDeg);
    end else if (s1_hue_q >= 9'(2 * SectorDeg)) begin
      sec_d    = SEC_GRN_BLU;
      sec_base = 9'(2 * SectorDeg);
    end else if (s1_hue_q >= 9'(SectorDeg)) begin
      sec_d    = SEC_GRN_RED;
      sec_base = 9'(SectorDeg);
    end else begin
      sec_d    = SEC_RED_GRN;
      sec_base = 9'd0;
    end
    offs = 6'(s1_hue_q - sec_base);
    // Even sectors ramp up, odd sectors ramp down.
    case (sec_d)
      SEC_RED_GRN, SEC_GRN_BLU, SEC_BLU_RED: frac_d = offs;
      default:                               frac_d = 6'(6'(SectorDeg) - offs);
    endcase
    inv_sat = 8'(8'(ChanMax) - s1_sat_q);
    plo_d   = 16'(s1_val_q) * 16'(inv_sat);
    pvs_d   = 16'(s1_val_q) * 16'(s1_sat_q);
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      s2_sec_q  <= sec_d;
      s2_frac_q <= frac_d;
      s2_val_q  <= s1_val_q;
      s2_plo_q  <= plo_d;
      s2_pvs_q  <= pvs_d;
    end
  end

  // ---------------- stage 3 ----------------
  assign num_d = 22'(22'(s2_plo_q) * 22'(SectorDeg)) + 22'(22'(s2_pvs_q) * 22'(s2_frac_q));

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      s3_num_q <= num_d;
      s3_plo_q <= s2_plo_q;
      s3_val_q <= s2_val_q;
      s3_sec_q <= s2_sec_q;
    end
  end

  // ---------------- stage 4 ----------------
  assign prod_d = 45'(s3_num_q) * 45'(MidRecip);
  // floor(x / 255) for x up to 255 * 255
  assign lo_sum = 17'(s3_plo_q) + 17'(s3_plo_q[15:8]) + 17'd1;
  assign lo_d   = lo_sum[15:8];

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      s4_prod_q <= prod_d;
      s4_lo_q   <= lo_d;
      s4_val_q  <= s3_val_q;
      s4_sec_q  <= s3_sec_q;
    end
  end

  // ---------------- stage 5 ----------------
  assign mid = s4_prod_q[MidShift +: 8];

  always_comb begin
    case (s4_sec_q)
      SEC_RED_GRN: begin red_d = s4_val_q; green_d = mid;      blue_d = s4_lo_q;  end
      SEC_GRN_RED: begin red_d = mid;      green_d = s4_val_q; blue_d = s4_lo_q;  end
      SEC_GRN_BLU: begin red_d = s4_lo_q;  green_d = s4_val_q; blue_d = mid;      end
      SEC_BLU_GRN: begin red_d = s4_lo_q;  green_d = mid;      blue_d = s4_val_q; end
      SEC_BLU_RED: begin red_d = mid;      green_d = s4_lo_q;  blue_d = s4_val_q; end
      default:     begin red_d = s4_val_q; green_d = s4_lo_q;  blue_d = mid;      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld5) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  // ---------------- assertions ----------------
  a_hue_folded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_hue_q < 9'(HueTurn)))
    else $error("folded hue out of range");

  a_frac_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (s2_frac_q <= 6'(SectorDeg)))
    else $error("sector ramp out of range");

  a_mid_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q |-> (s4_prod_q[44:MidShift] <= 9'(s4_val_q)) && (s4_lo_q <= s4_val_q))
    else $error("middle or smallest channel exceeds brightness");

  a_stage_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_valid_q && !ld4) |=> (s4_valid_q && $stable(s4_prod_q) && $stable(s4_sec_q)))
    else $error("stalled stage 4 beat lost or changed");

endmodule
